### design/rn_pkg.sv
`default_nettype none

package rn_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_GCD  = 5'b00010,
    ST_QN   = 5'b00100,
    ST_QD   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_e;

  // Status of the shared divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

`default_nettype wire

### design/rn_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
// A start pulse loads the operands; done pulses once, as the last quotient bit is registered.
module rn_div #(
  parameter int WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [WIDTH-1:0] dividend_i,
  input  wire logic [WIDTH-1:0] divisor_i,
  output rn_pkg::div_status_t   status_o,
  output logic      [WIDTH-1:0] quotient_o,
  output logic      [WIDTH-1:0] remainder_o
);

  localparam int CW = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;

  logic [WIDTH:0]   rem_sh;
  logic [WIDTH:0]   rem_sub;
  logic             ge;

  assign rem_sh  = {rem_q, quo_q[WIDTH-1]};
  assign ge      = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops safely
      rem_d = ge ? rem_sub[WIDTH-1:0] : rem_sh[WIDTH-1:0];
      quo_d = {quo_q[WIDTH-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(WIDTH - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i && (cnt_q != CW'(WIDTH - 1)) |=> busy_q && !done_q)
    else $error("divider stopped early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");

endmodule

`default_nettype wire

### design/rational_normalize.sv
`default_nettype none

// Channel  Dir  Handshake                     Payload
// s_axis   in   s_axis_tvalid/s_axis_tready   tdata: numerator_in, denominator_in
// m_axis   out  m_axis_tvalid/m_axis_tready   tdata: reduced_numerator,
//                                             reduced_denominator; tuser: invalid
//
// One item at a time: s_axis_tready is high only while the block is idle.
// Every Euclid remainder step and both final quotients run in turn on the one
// bit-serial divider, one quotient bit per cycle; 0/0 bypasses the divider.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle.
// The result holds on m_axis until taken; the input side stays closed meanwhile.
module rational_normalize #(
  parameter int WIDTH = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // numerator_in [WIDTH-1:0], denominator_in [2*WIDTH-1:WIDTH], zero pad
  input  wire logic [((2*WIDTH+7)/8)*8-1:0]        s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // reduced_numerator [WIDTH-1:0], reduced_denominator [2*WIDTH-2:WIDTH], zero pad
  output logic [((2*WIDTH+6)/8)*8-1:0]             m_axis_tdata,
  // invalid [0]
  output logic                                     m_axis_tuser
);

  localparam int OUT_W = ((2*WIDTH+6)/8)*8;

  rn_pkg::state_e      state_q, state_d;
  rn_pkg::div_status_t div_st;

  logic             neg_q, neg_d;
  logic             inv_q, inv_d;
  logic [WIDTH-1:0] nm_q, nm_d;
  logic [WIDTH-1:0] dm_q, dm_d;
  logic [WIDTH-1:0] b_q, b_d;
  logic [WIDTH-1:0] g_q, g_d;
  logic [WIDTH-1:0] qn_q, qn_d;
  logic [WIDTH-1:0] qd_q, qd_d;
  logic             start_q, start_d;
  logic [WIDTH-1:0] dvd_q, dvd_d;
  logic [WIDTH-1:0] dvs_q, dvs_d;

  logic [WIDTH-1:0] quo, rem;
  logic [WIDTH-1:0] n_in, d_in, n_mag, d_mag;
  logic [WIDTH-1:0] num_out;

  assign n_in  = s_axis_tdata[WIDTH-1:0];
  assign d_in  = s_axis_tdata[2*WIDTH-1:WIDTH];
  assign n_mag = n_in[WIDTH-1] ? (~n_in + 1'b1) : n_in;
  assign d_mag = d_in[WIDTH-1] ? (~d_in + 1'b1) : d_in;

  rn_div #(.WIDTH(WIDTH)) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_q),
    .dividend_i  (dvd_q),
    .divisor_i   (dvs_q),
    .status_o    (div_st),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  always_comb begin
    state_d = state_q;
    neg_d   = neg_q;
    inv_d   = inv_q;
    nm_d    = nm_q;
    dm_d    = dm_q;
    b_d     = b_q;
    g_d     = g_q;
    qn_d    = qn_q;
    qd_d    = qd_q;
    start_d = 1'b0;
    dvd_d   = dvd_q;
    dvs_d   = dvs_q;
    case (state_q)
      rn_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          neg_d = n_in[WIDTH-1] ^ d_in[WIDTH-1];
          nm_d  = n_mag;
          dm_d  = d_mag;
          inv_d = 1'b0;
          if (n_mag == '0 && d_mag == '0) begin
            inv_d   = 1'b1;
            neg_d   = 1'b0;
            qn_d    = '0;
            qd_d    = '0;
            state_d = rn_pkg::ST_OUT;
          end else if (d_mag == '0) begin
            // gcd is the numerator itself
            g_d     = n_mag;
            start_d = 1'b1;
            dvd_d   = n_mag;
            dvs_d   = n_mag;
            state_d = rn_pkg::ST_QN;
          end else begin
            b_d     = d_mag;
            start_d = 1'b1;
            dvd_d   = n_mag;
            dvs_d   = d_mag;
            state_d = rn_pkg::ST_GCD;
          end
        end
      end
      rn_pkg::ST_GCD: begin
        if (div_st.done) begin
          start_d = 1'b1;
          if (rem == '0) begin
            g_d     = b_q;
            dvd_d   = nm_q;
            dvs_d   = b_q;
            state_d = rn_pkg::ST_QN;
          end else begin
            b_d   = rem;
            dvd_d = b_q;
            dvs_d = rem;
          end
        end
      end
      rn_pkg::ST_QN: begin
        if (div_st.done) begin
          qn_d    = quo;
          start_d = 1'b1;
          dvd_d   = dm_q;
          dvs_d   = g_q;
          state_d = rn_pkg::ST_QD;
        end
      end
      rn_pkg::ST_QD: begin
        if (div_st.done) begin
          qd_d    = quo;
          state_d = rn_pkg::ST_OUT;
        end
      end
      rn_pkg::ST_OUT: begin
        if (m_axis_tready) begin
          state_d = rn_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rn_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rn_pkg::ST_IDLE;
      start_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    inv_q <= inv_d;
    nm_q  <= nm_d;
    dm_q  <= dm_d;
    b_q   <= b_d;
    g_q   <= g_d;
    qn_q  <= qn_d;
    qd_q  <= qd_d;
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
  end

  // a zero quotient negates to zero, so no special case for 0/x
  assign num_out       = neg_q ? (~qn_q + 1'b1) : qn_q;
  assign s_axis_tready = (state_q == rn_pkg::ST_IDLE);
  assign m_axis_tvalid = (state_q == rn_pkg::ST_OUT);
  assign m_axis_tdata  = OUT_W'({qd_q[WIDTH-2:0], num_out});
  assign m_axis_tuser  = inv_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == rn_pkg::ST_IDLE) |-> !div_st.busy && !div_st.done)
    else $error("divider active while idle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == rn_pkg::ST_GCD) || (state_q == rn_pkg::ST_QN)
                    || (state_q == rn_pkg::ST_QD))
    else $error("divider result with no step waiting");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> dvs_q != '0)
    else $error("divide by zero issued");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("invalid result with nonzero data");

endmodule

`default_nettype wire
